[src/msw_pkg.sv]
// shared types, constants and register codes of the mid/side stereo width block
package msw_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DECIMATION  = 4;
  localparam int CORR_WINDOW = 100;

  localparam int PHASE_W     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int CNT_W       = $clog2(CORR_WINDOW + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int ACC_W       = SAMPLE_BITS + 4;
  localparam int MUL_B_W     = 17;
  localparam int PROD_W      = ACC_W + MUL_B_W;
  localparam int GAIN_FRAC   = 12;
  localparam int WIDTH_FRAC  = 14;
  localparam int CORR_W      = 16;
  localparam int CORR_FRAC   = 14;
  localparam int RECIP_SH    = 12;
  localparam int RECIP_INT   = ((1 << (CORR_FRAC + RECIP_SH)) + CORR_WINDOW - 1) / CORR_WINDOW;
  localparam int RECIP_W     = $clog2(RECIP_INT + 1);
  localparam int CPROD_W     = CNT_W + RECIP_W;
  localparam int QUIET_W     = SAMPLE_BITS - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 23;

  localparam logic [RECIP_W-1:0] CORR_RECIP = RECIP_W'(RECIP_INT);

  localparam logic [15:0] WIDTH_MAX  = 16'd32768;
  localparam logic signed [15:0] BAL_MAX = 16'sd16384;
  localparam logic signed [15:0] BAL_MIN = -16'sd16384;
  localparam logic signed [15:0] BAL_DEAD = 16'sd16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_MID     = 3'd1,
    REG_SIDE    = 3'd2,
    REG_BALANCE = 3'd3,
    REG_MONO    = 3'd4,
    REG_QUIET   = 3'd5
  } msw_reg_e;

  typedef enum logic [1:0] {
    BAL_NONE,
    BAL_RIGHT,
    BAL_LEFT
  } msw_bal_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MID,
    B_SIDE_W,
    B_SIDE_G,
    B_DEC,
    B_BAL,
    B_FIN,
    B_CORR,
    B_OUT
  } msw_back_state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } msw_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic signed [CORR_W-1:0]      correlation_value;
    logic                          correlation_new;
  } msw_out_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mid_h;
    logic signed [SAMPLE_BITS-1:0] side_h;
    logic                          meter;
  } msw_job_t;

  typedef struct packed {
    logic [15:0]        width_eff;
    logic [13:0]        mid_gain;
    logic [13:0]        side_gain;
    msw_bal_e           bal_sel;
    logic [14:0]        bal_factor;
    logic               mono;
    logic [QUIET_W-1:0] quiet;
  } msw_cfg_t;

endpackage

[src/msw_front.sv]
// front end: request intake, decimation tagging and half sum / half difference
module msw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  msw_pkg::msw_in_t in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output msw_pkg::msw_job_t job_o
);
  import msw_pkg::*;

  logic [PHASE_W-1:0]          phase_q, phase_d;
  logic signed [SAMPLE_BITS:0] sum_w, diff_w;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign sum_w  = {in_data_i.left_in[SAMPLE_BITS-1], in_data_i.left_in}
                + {in_data_i.right_in[SAMPLE_BITS-1], in_data_i.right_in};
  assign diff_w = {in_data_i.left_in[SAMPLE_BITS-1], in_data_i.left_in}
                - {in_data_i.right_in[SAMPLE_BITS-1], in_data_i.right_in};

  assign job_o.mid_h  = $signed(sum_w[SAMPLE_BITS:1]);
  assign job_o.side_h = $signed(diff_w[SAMPLE_BITS:1]);
  assign job_o.meter  = (phase_q == '0);

  always_comb begin
    phase_d = phase_q;
    if (q_push_o) begin
      if (phase_q == PHASE_W'(DECIMATION - 1)) begin
        phase_d = '0;
      end else begin
        phase_d = phase_q + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

[src/msw_fifo.sv]
// short queue between front end and back end
module msw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  msw_pkg::msw_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output msw_pkg::msw_job_t pop_data_o
);
  import msw_pkg::*;

  msw_job_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/msw_back.sv]
// back end: gain sequencer on one shared multiplier, saturation and correlation meter
module msw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msw_pkg::msw_cfg_t  cfg_i,
  input  logic               job_valid_i,
  input  msw_pkg::msw_job_t  job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output msw_pkg::msw_out_t  out_data_o
);
  import msw_pkg::*;

  msw_back_state_e state_q, state_d;

  logic signed [ACC_W-1:0]       mid_q, mid_d, side_q, side_d;
  logic signed [ACC_W-1:0]       lo_q, lo_d, ro_q, ro_d;
  logic signed [SAMPLE_BITS-1:0] los_q, los_d, ros_q, ros_d;
  logic                          meter_q, meter_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic signed [CORR_W-1:0]      corr_q, corr_d;
  logic                          new_q, new_d;
  logic [CNT_W-1:0]              mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic                          out_valid_q, out_valid_d;
  msw_out_t                      out_data_q, out_data_d;

  logic signed [ACC_W-1:0]       mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      prod, prod_g, prod_w;

  logic signed [ACC_W:0]         mono_sum;
  logic signed [ACC_W-1:0]       lo_m, ro_m;
  logic signed [SAMPLE_BITS-1:0] lo_s, ro_s;
  logic [SAMPLE_BITS-1:0]        lo_abs, ro_abs;
  logic                          loud;
  logic signed [SUM_W-1:0]       sum_inc;
  logic [CNT_W-1:0]              cnt_inc;
  logic [CNT_W-1:0]              sum_mag;
  logic [CPROD_W-1:0]            corr_prod;
  logic [CORR_W-1:0]             quo;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-SAMPLE_BITS:0] top;
    top = v[ACC_W-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  assign prod   = mul_a * mul_b;
  assign prod_g = prod >>> GAIN_FRAC;
  assign prod_w = prod >>> WIDTH_FRAC;

  assign mono_sum = {lo_q[ACC_W-1], lo_q} + {ro_q[ACC_W-1], ro_q};
  assign lo_m     = cfg_i.mono ? $signed(mono_sum[ACC_W:1]) : lo_q;
  assign ro_m     = cfg_i.mono ? $signed(mono_sum[ACC_W:1]) : ro_q;
  assign lo_s     = sat_sample(lo_m);
  assign ro_s     = sat_sample(ro_m);
  assign lo_abs   = lo_s[SAMPLE_BITS-1] ? (~lo_s + SAMPLE_BITS'(1)) : lo_s;
  assign ro_abs   = ro_s[SAMPLE_BITS-1] ? (~ro_s + SAMPLE_BITS'(1)) : ro_s;
  assign loud     = (lo_abs > {1'b0, cfg_i.quiet}) && (ro_abs > {1'b0, cfg_i.quiet});
  assign sum_inc  = (lo_s[SAMPLE_BITS-1] == ro_s[SAMPLE_BITS-1]) ?
                    sum_q + SUM_W'(1) : sum_q - SUM_W'(1);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign sum_mag  = sum_inc[SUM_W-1] ? CNT_W'(-sum_inc) : CNT_W'(sum_inc);

  // magnitude times 2^14 / window through a reciprocal multiply
  assign corr_prod = mag_q * CORR_RECIP;
  assign quo       = {1'b0, corr_prod[RECIP_SH+CORR_W-2:RECIP_SH]};

  assign job_pop_o   = (state_q == B_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    mid_d       = mid_q;
    side_d      = side_q;
    lo_d        = lo_q;
    ro_d        = ro_q;
    los_d       = los_q;
    ros_d       = ros_q;
    meter_d     = meter_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    corr_d      = corr_q;
    new_d       = new_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_a       = '0;
    mul_b       = '0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          mid_d   = {{(ACC_W-SAMPLE_BITS){job_i.mid_h[SAMPLE_BITS-1]}}, job_i.mid_h};
          side_d  = {{(ACC_W-SAMPLE_BITS){job_i.side_h[SAMPLE_BITS-1]}}, job_i.side_h};
          meter_d = job_i.meter;
          state_d = B_MID;
        end
      end
      B_MID: begin
        mul_a   = mid_q;
        mul_b   = $signed({{(MUL_B_W-14){1'b0}}, cfg_i.mid_gain});
        mid_d   = $signed(prod_g[ACC_W-1:0]);
        state_d = B_SIDE_W;
      end
      B_SIDE_W: begin
        mul_a   = side_q;
        mul_b   = $signed({{(MUL_B_W-16){1'b0}}, cfg_i.width_eff});
        side_d  = $signed(prod_w[ACC_W-1:0]);
        state_d = B_SIDE_G;
      end
      B_SIDE_G: begin
        mul_a   = side_q;
        mul_b   = $signed({{(MUL_B_W-14){1'b0}}, cfg_i.side_gain});
        side_d  = $signed(prod_g[ACC_W-1:0]);
        state_d = B_DEC;
      end
      B_DEC: begin
        lo_d    = mid_q + side_q;
        ro_d    = mid_q - side_q;
        state_d = (cfg_i.bal_sel == BAL_NONE) ? B_FIN : B_BAL;
      end
      B_BAL: begin
        mul_a = (cfg_i.bal_sel == BAL_RIGHT) ? ro_q : lo_q;
        mul_b = $signed({{(MUL_B_W-15){1'b0}}, cfg_i.bal_factor});
        if (cfg_i.bal_sel == BAL_RIGHT) begin
          ro_d = $signed(prod_w[ACC_W-1:0]);
        end else begin
          lo_d = $signed(prod_w[ACC_W-1:0]);
        end
        state_d = B_FIN;
      end
      B_FIN: begin
        los_d   = lo_s;
        ros_d   = ro_s;
        new_d   = 1'b0;
        state_d = B_OUT;
        if (meter_q && loud) begin
          if (cnt_inc == CNT_W'(CORR_WINDOW)) begin
            neg_d   = sum_inc[SUM_W-1];
            mag_d   = sum_mag;
            sum_d   = '0;
            cnt_d   = '0;
            state_d = B_CORR;
          end else begin
            sum_d = sum_inc;
            cnt_d = cnt_inc;
          end
        end
      end
      B_CORR: begin
        corr_d  = neg_q ? $signed(-quo) : $signed(quo);
        new_d   = 1'b1;
        state_d = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d                  = 1'b1;
          out_data_d.left_out          = los_q;
          out_data_d.right_out         = ros_q;
          out_data_d.correlation_value = corr_q;
          out_data_d.correlation_new   = new_q;
          state_d                      = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mid_q      <= mid_d;
    side_q     <= side_d;
    lo_q       <= lo_d;
    ro_q       <= ro_d;
    los_q      <= los_d;
    ros_q      <= ros_d;
    meter_q    <= meter_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      corr_q      <= '0;
      new_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      corr_q      <= corr_d;
      new_q       <= new_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[src/mid_side_stereo_width.sv]
// Mid/side stereo width processor top level: configuration registers, front end, queue and
// back end. The back end takes one stereo pair at a time through its states, with B_BAL added
// when balance is active, since its gain, width and balance products run one after another on
// a single shared multiplier; the pair that closes a correlation window also passes B_CORR to
// scale the sign sum by the window length with a reciprocal multiply. The front end tags every
// DECIMATION-th pair for the meter and hands pairs to a two-entry queue, so up to two
// further pairs are taken while the back end works and one result waits in the output register.
module mid_side_stereo_width (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  msw_pkg::msw_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output msw_pkg::msw_out_t                 out_data_o,
  input  logic                              cfg_we_i,
  input  logic [msw_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [msw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import msw_pkg::*;

  logic [15:0]         width_q;
  logic [13:0]         mid_gain_q;
  logic [13:0]         side_gain_q;
  logic signed [15:0]  balance_q;
  logic                mono_q;
  logic [QUIET_W-1:0]  quiet_q;

  logic signed [15:0]  bal_clamp;
  logic signed [16:0]  bal_ext;
  logic signed [16:0]  fac_right, fac_left;
  msw_cfg_t            cfg;

  logic                q_full, q_push, q_valid, q_pop;
  msw_job_t            job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 16'd16384;
      mid_gain_q  <= 14'd4096;
      side_gain_q <= 14'd4096;
      balance_q   <= '0;
      mono_q      <= 1'b0;
      quiet_q     <= QUIET_W'(26527);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_WIDTH:   width_q     <= cfg_data_i[15:0];
        REG_MID:     mid_gain_q  <= cfg_data_i[13:0];
        REG_SIDE:    side_gain_q <= cfg_data_i[13:0];
        REG_BALANCE: balance_q   <= $signed(cfg_data_i[15:0]);
        REG_MONO:    mono_q      <= cfg_data_i[0];
        REG_QUIET:   quiet_q     <= cfg_data_i[QUIET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (balance_q > BAL_MAX) begin
      bal_clamp = BAL_MAX;
    end else if (balance_q < BAL_MIN) begin
      bal_clamp = BAL_MIN;
    end else begin
      bal_clamp = balance_q;
    end
  end

  assign bal_ext   = {bal_clamp[15], bal_clamp};
  assign fac_right = 17'sd16384 + bal_ext;
  assign fac_left  = 17'sd16384 - bal_ext;

  always_comb begin
    cfg.width_eff  = (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;
    cfg.mid_gain   = mid_gain_q;
    cfg.side_gain  = side_gain_q;
    cfg.mono       = mono_q;
    cfg.quiet      = quiet_q;
    cfg.bal_sel    = BAL_NONE;
    cfg.bal_factor = fac_left[14:0];
    if (bal_clamp < -BAL_DEAD) begin
      cfg.bal_sel    = BAL_RIGHT;
      cfg.bal_factor = fac_right[14:0];
    end else if (bal_clamp > BAL_DEAD) begin
      cfg.bal_sel    = BAL_LEFT;
    end
  end

  msw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .job_o      (job_in)
  );

  msw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (job_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (job_out)
  );

  msw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/msw_checker.sv]
// port-level checker for the stereo width block and its bind
module msw_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  msw_pkg::msw_out_t                 out_data_o
);
  import msw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result shown during reset");

  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.correlation_value <= 16'sd16384) &&
                    (out_data_o.correlation_value >= -16'sd16384))
    else $error("correlation out of range");

  a_corr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.correlation_new && $past(out_valid_o) &&
    !$past(out_ready_i) |-> $stable(out_data_o.correlation_value))
    else $error("correlation moved without an update");

endmodule

bind mid_side_stereo_width msw_checker u_msw_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the mid/side stereo width block, with its own model of the datapath
module tb_top;
  import msw_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_SHOWN    = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
  localparam int WIDTH_UNITY   = 16384;
  localparam int GAIN_UNITY    = 4096;
  localparam int QUIET_DEFAULT = 26527;

  logic clk   = 1'b0;
  logic rst_n;

  logic     in_valid = 1'b0;
  logic     in_ready;
  msw_in_t  in_data  = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  msw_out_t out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_cnt     = 0;
  int mismatch_cnt  = 0;

  msw_out_t processed_q[$];

  logic [15:0]              width_cfg = 16'd16384;
  logic [13:0]              mid_cfg   = 14'd4096;
  logic [13:0]              side_cfg  = 14'd4096;
  logic signed [15:0]       bal_cfg   = '0;
  logic                     mono_cfg  = 1'b0;
  logic [QUIET_W-1:0]       quiet_cfg = 23'd26527;

  logic [PHASE_W-1:0]       decim_q    = '0;
  logic signed [SUM_W-1:0]  sign_sum_q = '0;
  logic [CNT_W-1:0]         counted_q  = '0;
  logic signed [CORR_W-1:0] corr_q     = '0;

  mid_side_stereo_width dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic msw_out_t process_pair(input msw_in_t p);
    longint l, r, w, bal, mg, sg, q, mid, side, lo, ro, corr;
    msw_out_t res;
    l   = p.left_in;
    r   = p.right_in;
    w   = width_cfg;
    mg  = mid_cfg;
    sg  = side_cfg;
    q   = quiet_cfg;
    bal = bal_cfg;
    if (w > 32768) w = 32768;
    if (bal > 16384) bal = 16384;
    if (bal < -16384) bal = -16384;

    mid  = (l + r) >>> 1;
    mid  = (mid * mg) >>> GAIN_FRAC;
    side = (l - r) >>> 1;
    side = (side * w) >>> WIDTH_FRAC;
    side = (side * sg) >>> GAIN_FRAC;
    lo = mid + side;
    ro = mid - side;
    if (bal < -16) ro = (ro * (16384 + bal)) >>> 14;
    else if (bal > 16) lo = (lo * (16384 - bal)) >>> 14;
    if (mono_cfg) begin
      lo = (lo + ro) >>> 1;
      ro = lo;
    end

    res.left_out        = clip_sample(lo);
    res.right_out       = clip_sample(ro);
    res.correlation_new = 1'b0;

    // meter looks at the saturated outputs
    if (decim_q == '0) begin
      lo = res.left_out;
      ro = res.right_out;
      if ((lo < 0 ? -lo : lo) > q && (ro < 0 ? -ro : ro) > q) begin
        if ((lo < 0) == (ro < 0)) sign_sum_q = sign_sum_q + 8'sd1;
        else sign_sum_q = sign_sum_q - 8'sd1;
        counted_q = counted_q + 1'b1;
        if (counted_q >= CORR_WINDOW) begin
          corr = (longint'(sign_sum_q) * 16384) / CORR_WINDOW;
          corr_q = corr[CORR_W-1:0];
          sign_sum_q = '0;
          counted_q = '0;
          res.correlation_new = 1'b1;
        end
      end
    end
    if (int'(decim_q) == DECIMATION - 1) decim_q = '0;
    else decim_q = decim_q + 1'b1;

    res.correlation_value = corr_q;
    return res;
  endfunction

  always @(posedge clk) begin
    if (in_valid && in_ready) processed_q.push_back(process_pair(in_data));
  end

  always @(posedge clk) begin
    msw_out_t want;
    if (out_valid && out_ready) begin
      if (processed_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
          $display("unexpected result: L=%0d R=%0d corr=%0d new=%0b", out_data.left_out,
                   out_data.right_out, out_data.correlation_value, out_data.correlation_new);
      end else begin
        want = processed_q.pop_front();
        if (out_data.left_out !== want.left_out || out_data.right_out !== want.right_out ||
            out_data.correlation_value !== want.correlation_value ||
            out_data.correlation_new !== want.correlation_new) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch: exp L=%0d R=%0d corr=%0d new=%0b, got L=%0d R=%0d corr=%0d new=%0b",
                     want.left_out, want.right_out, want.correlation_value,
                     want.correlation_new, out_data.left_out, out_data.right_out,
                     out_data.correlation_value, out_data.correlation_new);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{left_in: l, right_in: r};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (processed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:   width_cfg = val[15:0];
      REG_MID:     mid_cfg   = val[13:0];
      REG_SIDE:    side_cfg  = val[13:0];
      REG_BALANCE: bal_cfg   = val[15:0];
      REG_MONO:    mono_cfg  = val[0];
      REG_QUIET:   quiet_cfg = val[QUIET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int w, input int m, input int s, input int b,
                               input int mono, input int q);
    stop_input();
    wait_idle();
    write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_MID, CFG_DATA_W'(m));
    write_reg(REG_SIDE, CFG_DATA_W'(s));
    write_reg(REG_BALANCE, CFG_DATA_W'(b));
    write_reg(REG_MONO, CFG_DATA_W'(mono));
    write_reg(REG_QUIET, CFG_DATA_W'(q));
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2, 3: return SAMPLE_BITS'(int'($urandom_range(131071)) - 65536);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] signed_mag(input bit neg);
    int mag;
    mag = $urandom_range(8388607, 1);
    return SAMPLE_BITS'(neg ? -mag : mag);
  endfunction

  task automatic test_directed();
    send_idle_pct = 13;
    recv_idle_pct = 58;
    send_pair(S_MAX, S_MAX);
    send_pair(S_MIN, S_MIN);
    send_pair(S_MAX, S_MIN);
    send_pair(S_MIN, S_MAX);
    send_pair(0, 0);
    send_pair(-1, -1);
    send_pair(1, -1);
    send_pair(-1, 0);
    send_pair(S_MAX, 0);
    send_pair(0, S_MIN);
    send_pair(1, 1);
    send_pair(-2, 3);
    send_pair(S_MAX, S_MAX - 1);
    send_pair(S_MIN + 1, S_MIN);
    send_pair(26528, -26528);
    send_pair(26527, 26527);
  endtask

  task automatic test_register_extremes();
    int sweep [12][6];
    sweep = '{
      '{0, 0, 0, 0, 0, 0},
      '{65535, 16383, 16383, 0, 0, 0},
      '{32768, GAIN_UNITY, 16383, -16384, 0, 100},
      '{32769, GAIN_UNITY, GAIN_UNITY, 16384, 0, QUIET_DEFAULT},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, -32768, 0, 1000},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 32767, 0, 1000},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 16, 0, QUIET_DEFAULT},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, -16, 0, QUIET_DEFAULT},
      '{20000, 5000, 3000, 17, 0, QUIET_DEFAULT},
      '{WIDTH_UNITY, 8192, GAIN_UNITY, -17, 1, QUIET_DEFAULT},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, -5000, 1, 8388607},
      '{WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 0, 0, 8388607}
    };
    send_idle_pct = 13;
    recv_idle_pct = 58;
    foreach (sweep[i]) begin
      load_settings(sweep[i][0], sweep[i][1], sweep[i][2], sweep[i][3], sweep[i][4],
                    sweep[i][5]);
      send_pair(S_MAX, S_MIN);
      send_pair(S_MIN, S_MAX);
      send_pair(S_MAX, S_MAX);
      send_pair(S_MIN, S_MIN);
      repeat (24) send_pair(pick_sample(), pick_sample());
    end
  endtask

  task automatic test_random_mix();
    int bal;
    send_idle_pct = 58;
    recv_idle_pct = 13;
    repeat (4) begin
      bal = $urandom_range(1) ? int'($urandom_range(32768)) - 16384
                              : int'($urandom_range(65535)) - 32768;
      load_settings($urandom_range(65535), $urandom_range(16383), $urandom_range(16383), bal,
                    $urandom_range(1), $urandom_range(200000));
      repeat (90) send_pair(pick_sample(), pick_sample());
    end
  endtask

  task automatic test_meter();
    int  len [3];
    int  bias [3];
    bit  neg;
    bit  same;
    len  = '{330, 330, 200};
    bias = '{100, 0, 60};
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (len[k]) begin
      case (k)
        0: load_settings(WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 0, 0, QUIET_DEFAULT);
        1: load_settings(WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 0, 0, 1000);
        default: load_settings(WIDTH_UNITY, GAIN_UNITY, GAIN_UNITY, 8000, 0,
                               $urandom_range(3000000));
      endcase
      repeat (len[k]) begin
        if ($urandom_range(9) == 0) begin
          send_pair(pick_sample(), pick_sample());
        end else begin
          neg  = $urandom_range(1);
          same = ($urandom_range(99) < bias[k]);
          send_pair(signed_mag(neg), signed_mag(same ? neg : !neg));
        end
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_mix();
    test_meter();
    stop_input();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && processed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/msw_pkg.sv
src/msw_front.sv
src/msw_fifo.sv
src/msw_back.sv
src/mid_side_stereo_width.sv
src/msw_checker.sv
tb/sv/tb_top.sv
